// File: hdl/tcc_pkg.sv
// Package for the timed color crossfade unit: fixed field widths, fixed-point
// constants, the shared multiply-add opcodes and the input clamp functions.
// No dependencies.
package tcc_pkg;

  localparam int FRAC_BITS = 16;               // fraction bits of the blend weight
  localparam int F_W       = FRAC_BITS + 1;    // weight spans 0..1.0 inclusive
  localparam int VAL_W     = 15;               // stored density / color width
  localparam int MA_W      = 31;               // widest multiplicand (blend sum)
  localparam int ACC_W     = MA_W + F_W;
  localparam int OUT_W     = 8;                // color output width
  localparam int CLR_SHIFT = 30;               // color blend fraction bits
  localparam int NCH       = 4;                // red, green, blue, density

  localparam logic [F_W-1:0]   F_ONE     = F_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] ONE_Q14   = 15'd16384;
  localparam logic [VAL_W-1:0] GRAY_Q14  = 15'd4915;
  localparam logic [ACC_W-1:0] RB_HALF   = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_W-1:0] CLR_HALF  = ACC_W'(1) << (CLR_SHIFT - 1);
  localparam logic [1:0]       CH_DENS   = 2'd3;

  typedef enum logic [1:0] {
    MAC_HOLD = 2'd0,
    MAC_LOAD = 2'd1,
    MAC_ADD  = 2'd2
  } mac_op_t;

  function automatic logic [VAL_W-1:0] clamp_dens(input logic signed [15:0] v);
    return v[15] ? '0 : v[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] clamp_color(input logic signed [15:0] v);
    logic [VAL_W-1:0] res;
    if (v[15]) begin
      res = '0;
    end else if (v[VAL_W-1:0] > ONE_Q14) begin
      res = ONE_Q14;
    end else begin
      res = v[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: hdl/tcc_if.sv
// Valid/ready channel interfaces of the crossfade unit: request beats in,
// result beats out. No dependencies.
interface tcc_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [31:0]        now_ms;
  logic signed [15:0] new_density;
  logic signed [15:0] new_red;
  logic signed [15:0] new_green;
  logic signed [15:0] new_blue;
  logic [15:0]        fade_ms;

  modport source (output valid, req_type, now_ms, new_density, new_red, new_green,
                  new_blue, fade_ms, input ready);
  modport sink (input valid, req_type, now_ms, new_density, new_red, new_green,
                new_blue, fade_ms, output ready);
endinterface

interface tcc_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [14:0] out_density;
  logic        fading;

  modport source (output valid, out_red, out_green, out_blue, out_density, fading,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_density, fading,
                output ready);
endinterface

// File: hdl/tcc_div.sv
// Radix-2 restoring divider for the blend weight: quot = (num << 16) / den,
// num <= den, one quotient bit per cycle. Depends on tcc_pkg.
module tcc_div import tcc_pkg::*; #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   num,
  input  logic [W-1:0]   den,
  output logic           done,
  output logic [F_W-1:0] quot
);

  localparam int CNT_W = $clog2(F_W);

  logic [W:0]       r;
  logic [W-1:0]     d;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic             ge;
  logic [W:0]       r_sub;

  assign ge    = r >= {1'b0, d};
  assign r_sub = ge ? (r - {1'b0, d}) : r;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_W'(FRAC_BITS);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below den after each subtract, so the shift fits W+1 bits
  always_ff @(posedge clk) begin
    if (start) begin
      r    <= {1'b0, num};
      d    <= den;
      quot <= '0;
    end else if (run) begin
      r    <= {r_sub[W-1:0], 1'b0};
      quot <= {quot[F_W-2:0], ge};
    end
  end

endmodule

// File: hdl/tcc_mac.sv
// Shared multiply-accumulate unit of the crossfade unit: one 31x17 multiply
// per cycle, loaded into or added onto the accumulator. Depends on tcc_pkg.
module tcc_mac import tcc_pkg::*; (
  input  logic             clk,
  input  mac_op_t          op,
  input  logic [MA_W-1:0]  a,
  input  logic [F_W-1:0]   b,
  output logic [ACC_W-1:0] acc
);

  logic [ACC_W-1:0] prod;

  assign prod = ACC_W'(a) * ACC_W'(b);

  always_ff @(posedge clk) begin
    case (op)
      MAC_LOAD: acc <= prod;
      MAC_ADD:  acc <= acc + prod;
      default:  acc <= acc;
    endcase
  end

endmodule

// File: hdl/timed_color_crossfade_unit.sv
// Timed color crossfade unit: top level with the sequencer and state store.
// Depends on tcc_pkg, tcc_if, tcc_div and tcc_mac.
//
// Usage: one request beat on req (query, or set a new target with a fade
// duration) gives exactly one result beat on rsp: the blended RGB at 8 bits,
// the blended Q8.8 density and the fading flag, all at the request's time.
// The block works on one request at a time; req.ready is high only while it
// is idle, so it takes no new beat before it is through with the last one.
// The steps from the accepting edge to result valid:
//   a query with no fade running blends the four channels,
//   a running fade first adds the 17-step serial divide for the weight,
//   a set with zero duration first adds the target update,
//   a set with nonzero duration first rebases the start values (four
//   blends, after a divide if a fade was already running).
// All blends share one multiply-accumulate unit.
// A finished result sits in the output register until rsp.ready; the next
// request is accepted meanwhile, and its result waits if the register is
// still full. Reset (rst, synchronous) clears the fade, sets the target and
// start colors to 0.3 gray and density to zero, and drops rsp.valid.
module timed_color_crossfade_unit import tcc_pkg::*; #(
  parameter int TIME_BITS     = 32,
  parameter int DURATION_BITS = 16,
  parameter int COLOR_OUT_MAX = 255
) (
  input  logic      clk,
  input  logic      rst,
  tcc_req_if.sink   req,
  tcc_rsp_if.source rsp
);

  localparam int END_W = ((TIME_BITS > DURATION_BITS) ? TIME_BITS : DURATION_BITS) + 1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_UPD   = 10'b00_0000_0010,
    ST_PREP  = 10'b00_0000_0100,
    ST_DIVW  = 10'b00_0000_1000,
    ST_MUL_S = 10'b00_0001_0000,
    ST_MUL_T = 10'b00_0010_0000,
    ST_ROUND = 10'b00_0100_0000,
    ST_SCALE = 10'b00_1000_0000,
    ST_CWB   = 10'b01_0000_0000,
    ST_LOAD  = 10'b10_0000_0000
  } state_t;

  state_t state;

  logic                     rebase;
  logic [TIME_BITS-1:0]     now_r;
  logic [DURATION_BITS-1:0] dur_r;
  logic [DURATION_BITS-1:0] dur_in;
  logic [VAL_W-1:0]         new_v    [NCH];
  logic [VAL_W-1:0]         start_v  [NCH];
  logic [VAL_W-1:0]         target_v [NCH];
  logic [DURATION_BITS-1:0] fade_len;
  logic [END_W-1:0]         fade_end;
  logic [F_W-1:0]           f_r;
  logic [1:0]               ch;
  logic                     fading_r;
  logic [OUT_W-1:0]         res_color [3];
  logic [VAL_W-1:0]         res_density;
  logic                     out_valid;

  // weight setup
  logic [END_W:0]           diff;
  logic                     ahead;
  logic                     over;
  logic                     active;
  logic [DURATION_BITS-1:0] rem;

  // shared unit
  mac_op_t          mac_op;
  logic [MA_W-1:0]  mac_a;
  logic [F_W-1:0]   mac_b;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] rb_sum;
  logic [ACC_W-1:0] clr_sum;
  logic [VAL_W-1:0] rb;
  logic [OUT_W-1:0] cval;

  logic             div_start;
  logic             div_done;
  logic [F_W-1:0]   div_quot;

  assign req.ready = (state == ST_IDLE);
  assign dur_in    = DURATION_BITS'(req.fade_ms);

  assign diff   = {1'b0, fade_end} - (END_W + 1)'(now_r);
  assign ahead  = !diff[END_W] && (diff[END_W-1:0] != '0);
  assign over   = diff[END_W-1:0] > END_W'(fade_len);
  assign rem    = over ? fade_len : diff[DURATION_BITS-1:0];
  assign active = ahead && (fade_len != '0);

  assign div_start = (state == ST_PREP) && active;

  assign rb_sum  = acc + RB_HALF;
  assign rb      = rb_sum[FRAC_BITS +: VAL_W];
  assign clr_sum = acc + CLR_HALF;
  assign cval    = clr_sum[CLR_SHIFT +: OUT_W];

  always_comb begin
    mac_op = MAC_HOLD;
    mac_a  = MA_W'(start_v[ch]);
    mac_b  = f_r;
    unique case (state)
      ST_MUL_S: mac_op = MAC_LOAD;
      ST_MUL_T: begin
        mac_op = MAC_ADD;
        mac_a  = MA_W'(target_v[ch]);
        mac_b  = F_ONE - f_r;
      end
      ST_SCALE: begin
        mac_op = MAC_LOAD;
        mac_a  = acc[MA_W-1:0];
        mac_b  = F_W'(COLOR_OUT_MAX);
      end
      default: mac_op = MAC_HOLD;
    endcase
  end

  tcc_div #(.W(DURATION_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rem),
    .den   (fade_len),
    .done  (div_done),
    .quot  (div_quot)
  );

  tcc_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  // sequencer and fade state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rebase   <= 1'b0;
      fade_len <= '0;
      fade_end <= '0;
      for (int i = 0; i < NCH; i++) begin
        start_v[i]  <= (i == int'(CH_DENS)) ? '0 : GRAY_Q14;
        target_v[i] <= (i == int'(CH_DENS)) ? '0 : GRAY_Q14;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            now_r         <= TIME_BITS'(req.now_ms);
            dur_r         <= dur_in;
            new_v[0]      <= clamp_color(req.new_red);
            new_v[1]      <= clamp_color(req.new_green);
            new_v[2]      <= clamp_color(req.new_blue);
            new_v[CH_DENS] <= clamp_dens(req.new_density);
            rebase        <= req.req_type && (dur_in != '0);
            if (req.req_type && (dur_in == '0)) begin
              state <= ST_UPD;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_UPD: begin
          for (int i = 0; i < NCH; i++) target_v[i] <= new_v[i];
          fade_len <= dur_r;
          fade_end <= END_W'(now_r) + END_W'(dur_r);
          rebase   <= 1'b0;
          state    <= ST_PREP;
        end
        ST_PREP: begin
          fading_r <= ahead;
          ch       <= '0;
          if (active) begin
            state <= ST_DIVW;
          end else begin
            f_r   <= '0;
            state <= ST_MUL_S;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            f_r   <= div_quot;
            state <= ST_MUL_S;
          end
        end
        ST_MUL_S: state <= ST_MUL_T;
        ST_MUL_T: state <= ST_ROUND;
        ST_ROUND: begin
          if (rebase) begin
            start_v[ch] <= rb;
            if (ch == CH_DENS) begin
              state <= ST_UPD;
            end else begin
              ch    <= ch + 2'd1;
              state <= ST_MUL_S;
            end
          end else if (ch == CH_DENS) begin
            res_density <= rb;
            state       <= ST_LOAD;
          end else begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: state <= ST_CWB;
        ST_CWB: begin
          res_color[ch] <= cval;
          ch            <= ch + 2'd1;
          state         <= ST_MUL_S;
        end
        ST_LOAD: begin
          if (!out_valid || rsp.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_LOAD) && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_LOAD) && (!out_valid || rsp.ready)) begin
      rsp.out_red     <= res_color[0];
      rsp.out_green   <= res_color[1];
      rsp.out_blue    <= res_color[2];
      rsp.out_density <= res_density;
      rsp.fading      <= fading_r;
    end
  end

  assign rsp.valid = out_valid;

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // a result beat appears only out of the final load step
  a_rsp_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == ST_LOAD))
    else $error("result valid without load step");

  // the weight never exceeds 1.0
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_S) |-> (f_r <= F_ONE))
    else $error("blend weight out of range");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVW))
    else $error("divider result not expected");

endmodule

// File: tb/sv/timed_color_crossfade_unit_test.sv
// Self-checking testbench for timed_color_crossfade_unit: directed and random
// query/set beats with a blend predictor class that scores result beats in order.
// Depends on tcc_pkg, tcc_if (tcc_req_if, tcc_rsp_if) and the unit's RTL.
module timed_color_crossfade_unit_test;
  import tcc_pkg::*;

  localparam int TIME_BITS     = 32;
  localparam int DURATION_BITS = 16;
  localparam int COLOR_OUT_MAX = 255;

  localparam int RANDOM_BEATS = 1330;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 10;

  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_SET   = 1'b1;

  typedef struct {
    logic               req_type;
    logic [31:0]        now_ms;
    logic signed [15:0] density;
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
    logic [15:0]        fade_ms;
  } fade_req_t;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] density;
    logic        fading;
  } blend_rsp_t;

  // Tracks the fade state and holds the blends still owed by the unit.
  class fade_tracker;
    logic [14:0] tgt_dens;
    logic [14:0] st_dens;
    logic [14:0] tgt_col[3];
    logic [14:0] st_col[3];
    logic [15:0] fade_len;
    logic [32:0] fade_end;
    blend_rsp_t  pending_blends[$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned sets;
    int unsigned mid_fade;

    function void clear();
      tgt_dens = '0;
      st_dens  = '0;
      foreach (tgt_col[i]) begin
        tgt_col[i] = GRAY_Q14;
        st_col[i]  = GRAY_Q14;
      end
      fade_len = '0;
      fade_end = '0;
      pending_blends.delete();
      mismatches = 0;
      requests   = 0;
      sets       = 0;
      mid_fade   = 0;
    endfunction

    function int unsigned outstanding();
      return pending_blends.size();
    endfunction

    // Weight of the start values, 16 fraction bits, 0..1.0
    function logic [16:0] weight_at(logic [31:0] now);
      logic [63:0] rem;
      if (fade_end <= {1'b0, now} || fade_len == '0) return '0;
      rem = 64'(fade_end - {1'b0, now});
      if (rem > 64'(fade_len)) rem = 64'(fade_len);  // time went backward
      return 17'((rem << 16) / 64'(fade_len));
    endfunction

    function logic [63:0] mix_value(logic [14:0] s, logic [14:0] t, logic [16:0] f);
      return 64'(s) * 64'(f) + 64'(t) * (64'd65536 - 64'(f));
    endfunction

    function logic [14:0] round_q(logic [63:0] v);
      return 15'((v + 64'd32768) >> 16);
    endfunction

    function logic [7:0] color_level(logic [63:0] v);
      return 8'((v * 64'(COLOR_OUT_MAX) + (64'd1 << 29)) >> 30);
    endfunction

    function logic [14:0] clamp_level(logic signed [15:0] v, logic [14:0] top);
      if (v < 0) return '0;
      if (v > $signed({1'b0, top})) return top;
      return v[14:0];
    endfunction

    function void take_request(fade_req_t r);
      blend_rsp_t  due;
      logic [14:0] new_dens;
      logic [14:0] new_col[3];
      logic [16:0] f;
      requests++;
      if (r.req_type == REQ_SET) begin
        sets++;
        new_dens   = clamp_level(r.density, 15'h7FFF);
        new_col[0] = clamp_level(r.red, ONE_Q14);
        new_col[1] = clamp_level(r.green, ONE_Q14);
        new_col[2] = clamp_level(r.blue, ONE_Q14);
        if (r.fade_ms != '0) begin
          // new fade starts from whatever is showing right now
          f = weight_at(r.now_ms);
          st_dens = round_q(mix_value(st_dens, tgt_dens, f));
          foreach (st_col[i]) st_col[i] = round_q(mix_value(st_col[i], tgt_col[i], f));
        end
        tgt_dens = new_dens;
        foreach (tgt_col[i]) tgt_col[i] = new_col[i];
        fade_len = r.fade_ms;
        fade_end = {1'b0, r.now_ms} + 33'(r.fade_ms);
      end
      f = weight_at(r.now_ms);
      if (f != '0 && f != F_ONE) mid_fade++;
      due.red     = color_level(mix_value(st_col[0], tgt_col[0], f));
      due.green   = color_level(mix_value(st_col[1], tgt_col[1], f));
      due.blue    = color_level(mix_value(st_col[2], tgt_col[2], f));
      due.density = round_q(mix_value(st_dens, tgt_dens, f));
      due.fading  = fade_end > {1'b0, r.now_ms};
      pending_blends.push_back(due);
    endfunction

    function void compare_result(blend_rsp_t got);
      blend_rsp_t due;
      bit         bad;
      if (pending_blends.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result beat: rgb %0d %0d %0d dens %0d fading %0b",
                   got.red, got.green, got.blue, got.density, got.fading);
        return;
      end
      due = pending_blends.pop_front();
      bad = (got.red !== due.red) || (got.green !== due.green) ||
            (got.blue !== due.blue) || (got.density !== due.density) ||
            (got.fading !== due.fading);
      if (bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: result mismatch at %0t", $realtime);
          $display("  expected rgb %0d %0d %0d dens %0d fading %0b",
                   due.red, due.green, due.blue, due.density, due.fading);
          $display("  actual   rgb %0d %0d %0d dens %0d fading %0b",
                   got.red, got.green, got.blue, got.density, got.fading);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  fade_tracker tracker;
  int unsigned cycle_count;
  int unsigned burst_left;
  logic [31:0] clock_ms;
  int unsigned span;

  int color_edges[6] = '{-32768, -1, 0, 16384, 16385, 32767};
  int dens_edges[5]  = '{-32768, -1, 0, 1, 32767};

  tcc_req_if req_if();
  tcc_rsp_if rsp_if();

  timed_color_crossfade_unit #(
    .TIME_BITS    (TIME_BITS),
    .DURATION_BITS(DURATION_BITS),
    .COLOR_OUT_MAX(COLOR_OUT_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ERROR: timeout after %0d cycles, %0d results outstanding",
             cycle_count, tracker.outstanding());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: the stall pattern switches at random among four modes
  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    int unsigned phase;
    blend_rsp_t  got;
    rsp_if.ready <= 1'b0;
    mode      = 0;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid && rsp_if.ready) begin
        got.red     = rsp_if.out_red;
        got.green   = rsp_if.out_green;
        got.blue    = rsp_if.out_blue;
        got.density = rsp_if.out_density;
        got.fading  = rsp_if.fading;
        tracker.compare_result(got);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      phase++;
      case (mode)
        0: rsp_if.ready <= 1'b1;
        1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
        2: rsp_if.ready <= ((phase % 7) < 2);
        default: rsp_if.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // Sends one request beat; bursts of random length with idle gaps between
  task automatic push_req(input fade_req_t r);
    if (burst_left == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 90 : 10)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.req_type;
    req_if.now_ms      <= r.now_ms;
    req_if.new_density <= r.density;
    req_if.new_red     <= r.red;
    req_if.new_green   <= r.green;
    req_if.new_blue    <= r.blue;
    req_if.fade_ms     <= r.fade_ms;
    do @(posedge clk); while (!req_if.ready);
    tracker.take_request(r);
  endtask

  task automatic push_fields(input logic kind, input logic [31:0] now, input int dens,
                             input int red, input int green, input int blue,
                             input int fade);
    fade_req_t r;
    r.req_type = kind;
    r.now_ms   = now;
    r.density  = 16'(dens);
    r.red      = 16'(red);
    r.green    = 16'(green);
    r.blue     = 16'(blue);
    r.fade_ms  = 16'(fade);
    push_req(r);
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  function automatic logic signed [15:0] pick_color();
    case ($urandom_range(0, 7))
      0, 1: return 16'($urandom);
      2:    return 16'(color_edges[$urandom_range(0, 5)]);
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  // Mostly a forward-moving clock with steps scaled to the last fade,
  // plus jumps backward, near the top of the range and anywhere.
  function automatic fade_req_t random_req();
    fade_req_t   r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom;
    else if (pick < 7) clock_ms = clock_ms - $urandom_range(0, span);
    else if (pick < 9) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * span);
    else clock_ms = clock_ms + $urandom_range(0, span / 3 + 1);
    r.req_type = ($urandom_range(0, 3) == 0) ? REQ_SET : REQ_QUERY;
    r.now_ms   = clock_ms;
    case ($urandom_range(0, 3))
      0: r.density = 16'(dens_edges[$urandom_range(0, 4)]);
      1: r.density = 16'($urandom);
      default: r.density = 16'($urandom_range(0, 32767));
    endcase
    r.red   = pick_color();
    r.green = pick_color();
    r.blue  = pick_color();
    pick = $urandom_range(0, 99);
    if (pick < 15) r.fade_ms = '0;
    else if (pick < 35) r.fade_ms = 16'($urandom_range(1, 16));
    else if (pick < 75) r.fade_ms = 16'($urandom_range(17, 1023));
    else if (pick < 90) r.fade_ms = 16'($urandom_range(1024, 65535));
    else r.fade_ms = 16'($urandom);
    if (r.req_type == REQ_SET && r.fade_ms != '0) span = r.fade_ms;
    return r;
  endfunction

  initial begin
    tracker = new();
    tracker.clear();
    burst_left = 0;
    clock_ms   = '0;
    span       = 64;
    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.req_type    <= REQ_QUERY;
    req_if.now_ms      <= '0;
    req_if.new_density <= '0;
    req_if.new_red     <= '0;
    req_if.new_green   <= '0;
    req_if.new_blue    <= '0;
    req_if.fade_ms     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset state: gray, no fade
    push_fields(REQ_QUERY, 32'd0, 0, 0, 0, 0, 0);
    // instant change with every clamp hit
    push_fields(REQ_SET, 32'd10, -32768, -1, 16384, 32767, 0);
    // fade from the old target, then sample along it and at its end
    push_fields(REQ_SET, 32'd20, 32767, 16385, 0, 8192, 1000);
    push_fields(REQ_QUERY, 32'd520, 1, 2, 3, 4, 5);
    push_fields(REQ_QUERY, 32'd1019, 0, 0, 0, 0, 0);
    push_fields(REQ_QUERY, 32'd1020, 0, 0, 0, 0, 0);
    push_fields(REQ_SET, 32'd1100, 16'h1234, 100, 16000, -32768, 65535);
    push_fields(REQ_QUERY, 32'd30000, 0, 0, 0, 0, 0);
    // retarget mid-fade, then time steps backward
    push_fields(REQ_SET, 32'd33000, 256, 16384, 16384, 16384, 400);
    push_fields(REQ_QUERY, 32'd33100, 0, 0, 0, 0, 0);
    push_fields(REQ_QUERY, 32'd32000, 0, 0, 0, 0, 0);
    // instant change during a fade; backward query then sees zero length
    push_fields(REQ_SET, 32'd33200, -5, 0, 0, 0, 0);
    push_fields(REQ_QUERY, 32'd33150, 0, 0, 0, 0, 0);
    // fade end beyond 32 bits
    push_fields(REQ_SET, 32'hFFFF_FF00, 32767, 16384, 4915, 1, 65535);
    push_fields(REQ_QUERY, 32'hFFFF_FFFF, -1, -1, -1, -1, 65535);
    push_fields(REQ_SET, 32'hFFFF_FFFF, 0, 32767, -32768, 9000, 1);
    push_fields(REQ_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    // huge jump back: weight saturates while rebasing
    push_fields(REQ_SET, 32'd5, 100, 200, 300, 400, 1);
    push_fields(REQ_QUERY, 32'd5, 0, 0, 0, 0, 0);
    push_fields(REQ_QUERY, 32'd6, 0, 0, 0, 0, 0);
    // exact half weight: density sum odd, ties round up
    push_fields(REQ_SET, 32'd6, 101, 16383, 1, 7, 16'h8000);
    push_fields(REQ_QUERY, 32'd6 + 32'h4000, 0, 0, 0, 0, 0);
    push_fields(REQ_QUERY, 32'd6 + 32'h8000, 0, 0, 0, 0, 0);
    wait_drain();

    clock_ms = 32'd1000;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      push_req(random_req());
      if (n % 300 == 299) wait_drain();
    end
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d request beats (%0d target updates, %0d blends taken mid-fade).",
             tracker.requests, tracker.sets, tracker.mid_fade);
    $display("Run included clamped targets, backward time, 33-bit fade ends and back-pressure.");
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d bad result beats, %0d results never arrived",
               tracker.mismatches, tracker.outstanding());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
